@@ rtl/core/fmprt_pkg.sv @@
// Types, codes and the rule compare for the first-match packet rule table.
// No dependencies; used by every module of the block.
`default_nettype none
package fmprt_pkg;

  localparam logic OP_ADD    = 1'b0;
  localparam logic OP_LOOKUP = 1'b1;

  localparam logic [7:0] PROTO_TCP = 8'd6;
  localparam logic [7:0] PROTO_UDP = 8'd17;

  typedef struct packed {
    logic [31:0] src_ip;
    logic [31:0] dst_ip;
    logic [15:0] sport;
    logic [15:0] dport;
    logic [7:0]  protocol;
    logic        any_protocol;
  } rule_t;

  typedef struct packed {
    logic  operation;
    rule_t fields;
  } req_t;

  typedef struct packed {
    logic       hit;
    logic [3:0] rule_index;
    logic       added;
  } res_t;

  // Rule entry against packet header; zero address or port is a wildcard.
  function automatic logic rule_hit(input rule_t r, input rule_t p);
    logic ok;
    ok = 1'b1;
    if (r.dst_ip != 32'd0 && r.dst_ip != p.dst_ip) ok = 1'b0;
    if (r.src_ip != 32'd0 && r.src_ip != p.src_ip) ok = 1'b0;
    if (!r.any_protocol && r.protocol != p.protocol) ok = 1'b0;
    if (p.protocol == PROTO_TCP || p.protocol == PROTO_UDP) begin
      if (r.sport != 16'd0 && r.sport != p.sport) ok = 1'b0;
      if (r.dport != 16'd0 && r.dport != p.dport) ok = 1'b0;
    end
    return ok;
  endfunction

endpackage
`default_nettype wire

@@ rtl/core/first_match_packet_rule_table.sv @@
// First-match five-tuple packet rule table, top level.
// Holds the input beat, list-mode register and output register; depends on
// fmprt_pkg and fmprt_ctrl.
//
// Usage:
//   Input channel (in_*): operation 0 appends a rule, 1 looks up a packet
//   header. One beat in gives exactly one beat out on the out_* channel.
//   cfg_wr_en / cfg_wr_data write the list mode, reported on every result.
//   Sequencing: an add goes straight to the done state. A lookup reads the
//   rule memory one entry per cycle and stops at the first matching rule; on a
//   miss it reads every stored rule, and with an empty table it goes straight
//   to the done state. The scan reads one entry at a time because the rule
//   memory has a single read port.
//   One item is in work at a time; in_stall is high from acceptance until
//   its result moves into the output register, so the next beat can be
//   taken while a result waits there.
//   Stall: with out_stall high a valid output register holds and the finished
//   result waits in the sequencer; nothing is dropped.
//   Reset (rst_n low, synchronous) empties the table and clears list mode.
//   Rule entries hold no reset value; only stored entries are ever read.
`default_nettype none
module first_match_packet_rule_table #(
  parameter int MAX_RULES = 16
) (
  input  wire         clk,
  input  wire         rst_n,
  input  wire         in_valid,
  output logic        in_stall,
  input  wire         in_operation,
  input  wire  [31:0] in_src_ip,
  input  wire  [31:0] in_dst_ip,
  input  wire  [7:0]  in_protocol,
  input  wire         in_any_protocol,
  input  wire  [15:0] in_sport,
  input  wire  [15:0] in_dport,
  output logic        out_valid,
  input  wire         out_stall,
  output logic        out_hit,
  output logic [3:0]  out_rule_index,
  output logic        out_added,
  output logic        out_white_list_mode,
  input  wire         cfg_wr_en,
  input  wire         cfg_wr_data
);

  logic            busy_r, busy_nxt;
  logic            start_r;
  logic            white_r;
  logic            out_valid_r, out_valid_nxt;
  fmprt_pkg::req_t req_r;
  fmprt_pkg::res_t res;
  fmprt_pkg::res_t out_res_r;
  logic            out_white_r;
  logic            done;
  logic            load_out;
  logic            in_acc;

  assign in_acc   = in_valid && !busy_r;
  assign load_out = done && (!out_valid_r || !out_stall);

  always_comb begin
    busy_nxt = busy_r;
    if (in_acc) busy_nxt = 1'b1;
    else if (load_out) busy_nxt = 1'b0;
    out_valid_nxt = out_valid_r;
    if (load_out) out_valid_nxt = 1'b1;
    else if (!out_stall) out_valid_nxt = 1'b0;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r      <= 1'b0;
      start_r     <= 1'b0;
      out_valid_r <= 1'b0;
      white_r     <= 1'b0;
    end else begin
      busy_r      <= busy_nxt;
      start_r     <= in_acc;
      out_valid_r <= out_valid_nxt;
      if (cfg_wr_en) white_r <= cfg_wr_data;
    end
    if (in_acc) begin
      req_r.operation           <= in_operation;
      req_r.fields.src_ip       <= in_src_ip;
      req_r.fields.dst_ip       <= in_dst_ip;
      req_r.fields.protocol     <= in_protocol;
      req_r.fields.any_protocol <= in_any_protocol;
      req_r.fields.sport        <= in_sport;
      req_r.fields.dport        <= in_dport;
    end
    if (load_out) begin
      out_res_r   <= res;
      out_white_r <= white_r;
    end
  end

  fmprt_ctrl #(
    .MAX_RULES (MAX_RULES)
  ) u_ctrl (
    .clk   (clk),
    .rst_n (rst_n),
    .start (start_r),
    .req   (req_r),
    .done  (done),
    .res   (res),
    .ack   (load_out)
  );

  assign in_stall            = busy_r;
  assign out_valid           = out_valid_r;
  assign out_hit             = out_res_r.hit;
  assign out_rule_index      = out_res_r.rule_index;
  assign out_added           = out_res_r.added;
  assign out_white_list_mode = out_white_r;

endmodule
`default_nettype wire

@@ rtl/core/fmprt_rule_mem.sv @@
// Rule storage: one write port, one read port with registered read data.
// Depends on fmprt_pkg for the rule entry type.
`default_nettype none
module fmprt_rule_mem #(
  parameter int DEPTH = 16,
  parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  wire               clk,
  input  wire               wr_en,
  input  wire  [AW-1:0]     wr_addr,
  input  fmprt_pkg::rule_t  wr_data,
  input  wire               rd_en,
  input  wire  [AW-1:0]     rd_addr,
  output fmprt_pkg::rule_t  rd_data
);

  fmprt_pkg::rule_t mem [DEPTH];
  fmprt_pkg::rule_t rd_data_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data_r <= mem[rd_addr];
    end
  end

  assign rd_data = rd_data_r;

endmodule
`default_nettype wire

@@ rtl/core/fmprt_ctrl.sv @@
// Sequencer: appends rules, scans the rule memory one entry per cycle on lookup.
// Depends on fmprt_pkg and fmprt_rule_mem.
`default_nettype none
module fmprt_ctrl #(
  parameter int MAX_RULES = 16
) (
  input  wire              clk,
  input  wire              rst_n,
  input  wire              start,
  input  fmprt_pkg::req_t  req,
  output logic             done,
  output fmprt_pkg::res_t  res,
  input  wire              ack
);

  localparam int AW = (MAX_RULES > 1) ? $clog2(MAX_RULES) : 1;
  localparam int CW = $clog2(MAX_RULES + 1);

  localparam logic [1:0] ST_IDLE = 2'd0;
  localparam logic [1:0] ST_SCAN = 2'd1;
  localparam logic [1:0] ST_DONE = 2'd2;

  logic [1:0]      state_r, state_nxt;
  logic [CW-1:0]   count_r, count_nxt;
  logic [CW-1:0]   iss_r, iss_nxt;
  logic [CW-1:0]   ret_r, ret_nxt;
  logic            pend_r, pend_nxt;
  fmprt_pkg::res_t res_r, res_nxt;

  logic             wr_en;
  logic             rd_en;
  fmprt_pkg::rule_t rd_data;
  logic             full;

  assign full  = (count_r == CW'(MAX_RULES));
  assign rd_en = (state_r == ST_SCAN) && (iss_r < count_r);
  assign wr_en = (state_r == ST_IDLE) && start && (req.operation == fmprt_pkg::OP_ADD) && !full;

  fmprt_rule_mem #(
    .DEPTH (MAX_RULES),
    .AW    (AW)
  ) u_mem (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (count_r[AW-1:0]),
    .wr_data (req.fields),
    .rd_en   (rd_en),
    .rd_addr (iss_r[AW-1:0]),
    .rd_data (rd_data)
  );

  always_comb begin
    state_nxt = state_r;
    count_nxt = count_r;
    iss_nxt   = iss_r;
    ret_nxt   = ret_r;
    pend_nxt  = 1'b0;
    res_nxt   = res_r;
    unique case (state_r)
      ST_IDLE: begin
        iss_nxt = '0;
        if (start) begin
          res_nxt = '0;
          if (req.operation == fmprt_pkg::OP_ADD) begin
            state_nxt = ST_DONE;
            if (!full) begin
              count_nxt     = count_r + CW'(1);
              res_nxt.added = 1'b1;
            end
          end else if (count_r == '0) begin
            state_nxt = ST_DONE;
          end else begin
            state_nxt = ST_SCAN;
          end
        end
      end
      ST_SCAN: begin
        if (rd_en) begin
          iss_nxt  = iss_r + CW'(1);
          ret_nxt  = iss_r;
          pend_nxt = 1'b1;
        end
        if (pend_r) begin
          if (fmprt_pkg::rule_hit(rd_data, req.fields)) begin
            res_nxt.hit        = 1'b1;
            res_nxt.rule_index = 4'(ret_r);
            state_nxt          = ST_DONE;
            pend_nxt           = 1'b0;
          end else if ((ret_r + CW'(1)) == count_r) begin
            state_nxt = ST_DONE;
            pend_nxt  = 1'b0;
          end
        end
      end
      ST_DONE: begin
        if (ack) begin
          state_nxt = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      count_r <= '0;
      pend_r  <= 1'b0;
    end else begin
      state_r <= state_nxt;
      count_r <= count_nxt;
      pend_r  <= pend_nxt;
    end
    iss_r <= iss_nxt;
    ret_r <= ret_nxt;
    res_r <= res_nxt;
  end

  assign done = (state_r == ST_DONE);
  assign res  = res_r;

endmodule
`default_nettype wire

@@ dv/tb_top.sv @@
// Self-checking testbench for first_match_packet_rule_table.
// Drives rule adds and packet lookups, predicts each result beat in a scoreboard
// class and compares every field of it; depends on fmprt_pkg and the RTL only.
`timescale 1ns / 1ps

module tb_top;

  typedef fmprt_pkg::rule_t rule_t;
  typedef fmprt_pkg::req_t  req_t;

  localparam logic       OP_ADD    = fmprt_pkg::OP_ADD;
  localparam logic       OP_LOOKUP = fmprt_pkg::OP_LOOKUP;
  localparam logic [7:0] PROTO_TCP = fmprt_pkg::PROTO_TCP;
  localparam logic [7:0] PROTO_UDP = fmprt_pkg::PROTO_UDP;

  localparam int RULES       = 16;
  localparam int CYCLE_LIMIT = 400000;
  localparam int HOLD_CYCLES = 400;
  localparam int DRAIN       = RULES + 8;
  localparam int PHASE_BEATS = 560;

  typedef struct packed {
    logic       hit;
    logic [3:0] rule_index;
    logic       added;
    logic       white;
  } verdict_t;

  class rule_table_scoreboard;
    rule_t       rules[RULES];
    int unsigned n_rules;
    bit          list_white;
    verdict_t    verdict_q[$];
    int unsigned mismatches;

    function bit agrees(rule_t r, rule_t p);
      bit ports;
      ports = (p.protocol == PROTO_TCP) || (p.protocol == PROTO_UDP);
      if (r.src_ip != 32'd0 && r.src_ip != p.src_ip) return 1'b0;
      if (r.dst_ip != 32'd0 && r.dst_ip != p.dst_ip) return 1'b0;
      if (!r.any_protocol && r.protocol != p.protocol) return 1'b0;
      if (ports && r.sport != 16'd0 && r.sport != p.sport) return 1'b0;
      if (ports && r.dport != 16'd0 && r.dport != p.dport) return 1'b0;
      return 1'b1;
    endfunction

    function void note_input(req_t r);
      verdict_t v;
      v = '0;
      v.white = list_white;
      if (r.operation == OP_ADD) begin
        if (n_rules < RULES) begin
          rules[n_rules] = r.fields;
          n_rules++;
          v.added = 1'b1;
        end
      end else begin
        for (int i = 0; i < n_rules; i++) begin
          if (agrees(rules[i], r.fields)) begin
            v.hit = 1'b1;
            v.rule_index = 4'(i);
            break;
          end
        end
      end
      verdict_q.insert(verdict_q.size(), v);
    endfunction

    function void check_result(verdict_t got);
      verdict_t want;
      if (verdict_q.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("unexpected result beat: hit %0b index %0d added %0b mode %0b",
                   got.hit, got.rule_index, got.added, got.white);
        return;
      end
      want = verdict_q.pop_front();
      if (got !== want) begin
        mismatches++;
        if (mismatches <= 10)
          $display("mismatch (exp/act): hit %0b/%0b index %0d/%0d added %0b/%0b mode %0b/%0b",
                   want.hit, got.hit, want.rule_index, got.rule_index,
                   want.added, got.added, want.white, got.white);
      end
    endfunction

    function int unsigned outstanding();
      return verdict_q.size();
    endfunction
  endclass

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_valid = 1'b0;
  logic        in_stall;
  logic        in_operation = 1'b0;
  logic [31:0] in_src_ip = '0;
  logic [31:0] in_dst_ip = '0;
  logic [7:0]  in_protocol = '0;
  logic        in_any_protocol = 1'b0;
  logic [15:0] in_sport = '0;
  logic [15:0] in_dport = '0;
  logic        out_valid;
  logic        out_stall = 1'b0;
  logic        out_hit;
  logic [3:0]  out_rule_index;
  logic        out_added;
  logic        out_white_list_mode;
  logic        cfg_wr_en = 1'b0;
  logic        cfg_wr_data = 1'b0;

  rule_table_scoreboard sb;
  int tx_idle_pct = 0;
  int rx_idle_pct = 0;
  bit hold_arm = 1'b0;
  bit hold_done = 1'b0;
  int hold_left = 0;
  int cycle_count = 0;

  first_match_packet_rule_table #(.MAX_RULES(RULES)) u_dut (
    .clk                 (clk),
    .rst_n               (rst_n),
    .in_valid            (in_valid),
    .in_stall            (in_stall),
    .in_operation        (in_operation),
    .in_src_ip           (in_src_ip),
    .in_dst_ip           (in_dst_ip),
    .in_protocol         (in_protocol),
    .in_any_protocol     (in_any_protocol),
    .in_sport            (in_sport),
    .in_dport            (in_dport),
    .out_valid           (out_valid),
    .out_stall           (out_stall),
    .out_hit             (out_hit),
    .out_rule_index      (out_rule_index),
    .out_added           (out_added),
    .out_white_list_mode (out_white_list_mode),
    .cfg_wr_en           (cfg_wr_en),
    .cfg_wr_data         (cfg_wr_data)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("Testbench completed WITH ERRORS");
      $finish;
    end
  end

  // result side: check accepted beats, then pick next stall
  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall)
      sb.check_result(verdict_t'({out_hit, out_rule_index, out_added, out_white_list_mode}));
    if (hold_left > 0) begin
      out_stall <= 1'b1;
      hold_left = hold_left - 1;
    end else if (hold_arm && !hold_done) begin
      hold_done = 1'b1;
      hold_left = HOLD_CYCLES - 1;
      out_stall <= 1'b1;
    end else begin
      out_stall <= ($urandom_range(99) < rx_idle_pct);
    end
  end

  function automatic req_t mk(logic op, logic [31:0] sa, logic [31:0] da, logic [7:0] pr,
                              logic anyp, logic [15:0] sp, logic [15:0] dp);
    req_t r;
    r.operation = op;
    r.fields.src_ip = sa;
    r.fields.dst_ip = da;
    r.fields.protocol = pr;
    r.fields.any_protocol = anyp;
    r.fields.sport = sp;
    r.fields.dport = dp;
    return r;
  endfunction

  function automatic logic [7:0] pick_proto();
    case ($urandom_range(3))
      0: return PROTO_TCP;
      1: return PROTO_UDP;
      2: return 8'd1;
      default: return 8'($urandom_range(255));
    endcase
  endfunction

  function automatic rule_t random_rule();
    rule_t f;
    f.src_ip = ($urandom_range(3) == 0) ? 32'd0 : 32'($urandom());
    f.dst_ip = ($urandom_range(3) == 0) ? 32'd0 : 32'($urandom());
    f.sport = ($urandom_range(2) == 0) ? 16'd0 : 16'($urandom_range(65535));
    f.dport = ($urandom_range(2) == 0) ? 16'd0 : 16'($urandom_range(65535));
    f.protocol = pick_proto();
    f.any_protocol = ($urandom_range(3) == 0);
    return f;
  endfunction

  // mostly lookups aimed at a stored rule, some off by one bit, some noise
  function automatic req_t random_item();
    req_t r;
    rule_t t;
    int unsigned k;
    int unsigned b;
    r.operation = ($urandom_range(29) == 0) ? OP_ADD : OP_LOOKUP;
    r.fields = random_rule();
    if (r.operation == OP_ADD) return r;
    r.fields.src_ip = 32'($urandom());
    r.fields.dst_ip = 32'($urandom());
    r.fields.sport = 16'($urandom_range(65535));
    r.fields.dport = 16'($urandom_range(65535));
    if (sb.n_rules != 0 && $urandom_range(9) < 7) begin
      k = $urandom_range(sb.n_rules - 1);
      t = sb.rules[k];
      if (t.src_ip != 32'd0) r.fields.src_ip = t.src_ip;
      if (t.dst_ip != 32'd0) r.fields.dst_ip = t.dst_ip;
      if (t.sport != 16'd0) r.fields.sport = t.sport;
      if (t.dport != 16'd0) r.fields.dport = t.dport;
      if (!t.any_protocol) r.fields.protocol = t.protocol;
      if ($urandom_range(3) == 0) begin
        b = $urandom_range(31);
        case ($urandom_range(4))
          0: r.fields.src_ip[b] = ~r.fields.src_ip[b];
          1: r.fields.dst_ip[b] = ~r.fields.dst_ip[b];
          2: r.fields.sport[b % 16] = ~r.fields.sport[b % 16];
          3: r.fields.dport[b % 16] = ~r.fields.dport[b % 16];
          default: r.fields.protocol[b % 8] = ~r.fields.protocol[b % 8];
        endcase
      end
    end
    r.fields.any_protocol = 1'($urandom_range(1));
    return r;
  endfunction

  task automatic send_beat(input req_t r);
    while ($urandom_range(99) < tx_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_operation <= r.operation;
    in_src_ip <= r.fields.src_ip;
    in_dst_ip <= r.fields.dst_ip;
    in_protocol <= r.fields.protocol;
    in_any_protocol <= r.fields.any_protocol;
    in_sport <= r.fields.sport;
    in_dport <= r.fields.dport;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    sb.note_input(r);
  endtask

  task automatic set_list_mode(input logic white);
    in_valid <= 1'b0;
    while (sb.outstanding() != 0) @(posedge clk);
    cfg_wr_en <= 1'b1;
    cfg_wr_data <= white;
    @(posedge clk);
    cfg_wr_en <= 1'b0;
    sb.list_white = white;
  endtask

  task automatic run_random(input int tx_pct, input int rx_pct);
    tx_idle_pct = tx_pct;
    rx_idle_pct <= rx_pct;
    repeat (PHASE_BEATS) send_beat(random_item());
  endtask

  initial begin
    sb = new();
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    set_list_mode(1'b1);
    send_beat(mk(OP_LOOKUP, 32'd0, 32'd0, 8'd0, 1'b0, 16'd0, 16'd0));
    send_beat(mk(OP_LOOKUP, '1, '1, '1, 1'b1, '1, '1));
    send_beat(mk(OP_ADD, '1, '1, '1, 1'b0, '1, '1));
    send_beat(mk(OP_LOOKUP, '1, '1, '1, 1'b0, '1, '1));
    send_beat(mk(OP_LOOKUP, '1, '1, '1, 1'b0, 16'd0, 16'd0));
    send_beat(mk(OP_ADD, 32'h0A00_0001, 32'd0, PROTO_TCP, 1'b0, 16'd0, 16'd80));
    send_beat(mk(OP_LOOKUP, 32'h0A00_0001, 32'hC0A8_0001, PROTO_TCP, 1'b0, 16'd1234, 16'd80));
    send_beat(mk(OP_LOOKUP, 32'h0A00_0001, 32'hC0A8_0001, PROTO_TCP, 1'b0, 16'd1234, 16'd81));
    send_beat(mk(OP_LOOKUP, 32'h0A00_0001, 32'hC0A8_0001, PROTO_UDP, 1'b0, 16'd1234, 16'd80));
    send_beat(mk(OP_ADD, 32'd0, 32'h0808_0808, PROTO_UDP, 1'b0, 16'd53, 16'd0));
    send_beat(mk(OP_LOOKUP, 32'h1234_5678, 32'h0808_0808, PROTO_UDP, 1'b0, 16'd53, 16'd999));
    send_beat(mk(OP_LOOKUP, 32'h1234_5678, 32'h0808_0808, PROTO_UDP, 1'b0, 16'd54, 16'd999));
    // any-protocol rule keeps a TCP number that must be ignored
    send_beat(mk(OP_ADD, 32'h0A00_0002, 32'd0, PROTO_TCP, 1'b1, 16'd1000, 16'd0));
    send_beat(mk(OP_LOOKUP, 32'h0A00_0002, 32'h0101_0101, 8'd1, 1'b0, 16'd7, 16'd7));
    send_beat(mk(OP_LOOKUP, 32'h0A00_0002, 32'h0101_0101, PROTO_TCP, 1'b0, 16'd1000, 16'd1));
    send_beat(mk(OP_LOOKUP, 32'h0A00_0002, 32'h0101_0101, PROTO_TCP, 1'b0, 16'd999, 16'd1));
    send_beat(mk(OP_ADD, 32'd0, 32'd0, 8'd0, 1'b0, 16'd0, 16'd0));
    send_beat(mk(OP_LOOKUP, 32'h5555_AAAA, 32'hAAAA_5555, 8'd0, 1'b0, 16'h8000, 16'h0001));
    send_beat(mk(OP_LOOKUP, 32'h0A00_0002, 32'h0202_0202, 8'd1, 1'b1, 16'd0, 16'd0));

    set_list_mode(1'b0);
    run_random(26, 51);
    set_list_mode(1'b1);
    run_random(51, 26);
    set_list_mode(1'b0);
    hold_arm <= 1'b1;
    run_random(0, 0);
    in_valid <= 1'b0;

    while (sb.outstanding() != 0) @(posedge clk);
    repeat (DRAIN) @(posedge clk);
    if (sb.mismatches == 0 && sb.outstanding() == 0)
      $display("Testbench completed without errors");
    else
      $display("Testbench completed WITH ERRORS");
    $finish;
  end

endmodule
